// File: sv/pcrqb_pkg.sv
package pcrqb_pkg;

    localparam int NUM_CORE_MAX_DEF = 4;
    localparam int NUM_TASKS_DEF    = 64;

    localparam int REQ_W    = 2;
    localparam int CORE_W   = 2;
    localparam int TASK_W   = 6;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    localparam int NCORES_W = 3;
    localparam int PERIOD_W = 8;
    localparam int MARGIN_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [NCORES_W-1:0] NUM_CORES_RST = 3'd4;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 8'd5;
    localparam logic [MARGIN_W-1:0] MARGIN_RST    = 7'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CORES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_MARGIN = 2'd2;

    localparam logic [REQ_W-1:0] REQ_ADMIT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READY    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CORE_W-1:0] core;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] create_time;
        logic              pinned;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   chosen_task;
        logic [CORE_W-1:0]   target_core;
        logic                moved;
    } out_item_t;

    typedef struct packed {
        logic                start;
        logic                load_init_even;
        logic                load_init_odd;
        logic                load_step;
        logic                admit_write;
        logic                home_from_mem;
        logic                enqueue;
        logic                tick_count;
        logic                pick_zero;
        logic                qscan_init_min;
        logic                qscan_init_free;
        logic                qscan_run;
        logic                take_read_pick;
        logic                take_read_last;
        logic                take_write;
        logic                move_commit;
        logic                set_result;
        logic [STATUS_W-1:0] result_status;
        logic                publish;
    } cmd_t;

    typedef struct packed {
        logic is_admit;
        logic is_ready;
        logic is_dispatch;
        logic task_ok;
        logic core_ok;
        logic core_odd;
        logic core_empty;
        logic balance_due;
        logic load_done;
        logic load_found;
        logic overload;
        logic qscan_done;
        logic qscan_found;
        logic pc_full;
        logic out_free;
    } stat_t;

endpackage

// File: sv/pcrqb_ctrl.sv
module pcrqb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pcrqb_pkg::stat_t stat,
    output pcrqb_pkg::cmd_t  cmd
);
    import pcrqb_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_LOAD_ADMIT = 4'd2;
    localparam logic [3:0] S_READY_WAIT = 4'd3;
    localparam logic [3:0] S_ENQ        = 4'd4;
    localparam logic [3:0] S_LOAD_BAL   = 4'd5;
    localparam logic [3:0] S_BAL_CHECK  = 4'd6;
    localparam logic [3:0] S_QSCAN_DISP = 4'd7;
    localparam logic [3:0] S_QSCAN_BAL  = 4'd8;
    localparam logic [3:0] S_BAL_FOUND  = 4'd9;
    localparam logic [3:0] S_TAKE_PICK  = 4'd10;
    localparam logic [3:0] S_TAKE_LAST  = 4'd11;
    localparam logic [3:0] S_TAKE_WR    = 4'd12;
    localparam logic [3:0] S_MOVE       = 4'd13;
    localparam logic [3:0] S_FINISH     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_admit || stat.is_ready) begin
                    if (!stat.task_ok) begin
                        state_next = S_FINISH;
                    end else if (stat.is_admit) begin
                        cmd.load_init_even = 1'b1;
                        state_next         = S_LOAD_ADMIT;
                    end else begin
                        state_next = S_READY_WAIT;
                    end
                end else if (!stat.core_ok) begin
                    state_next = S_FINISH;
                end else if (stat.is_dispatch) begin
                    if (stat.core_empty) begin
                        cmd.set_result    = 1'b1;
                        cmd.result_status = ST_NONE;
                        state_next        = S_FINISH;
                    end else if (stat.core_odd) begin
                        cmd.qscan_init_min = 1'b1;
                        state_next         = S_QSCAN_DISP;
                    end else begin
                        cmd.pick_zero = 1'b1;
                        state_next    = S_TAKE_PICK;
                    end
                end else begin
                    cmd.set_result    = 1'b1;
                    cmd.result_status = ST_NONE;
                    state_next        = S_FINISH;
                    if (!stat.core_odd) begin
                        cmd.tick_count = 1'b1;
                        if (stat.balance_due) begin
                            cmd.load_init_odd = 1'b1;
                            state_next        = S_LOAD_BAL;
                        end
                    end
                end
            end
            S_LOAD_ADMIT: begin
                if (!stat.load_done) begin
                    cmd.load_step = 1'b1;
                end else begin
                    cmd.admit_write = 1'b1;
                    state_next      = S_ENQ;
                end
            end
            S_READY_WAIT: begin
                cmd.home_from_mem = 1'b1;
                state_next        = S_ENQ;
            end
            S_ENQ: begin
                cmd.enqueue = 1'b1;
                state_next  = S_FINISH;
            end
            S_LOAD_BAL: begin
                if (!stat.load_done) begin
                    cmd.load_step = 1'b1;
                end else begin
                    state_next = S_BAL_CHECK;
                end
            end
            S_BAL_CHECK: begin
                if (stat.load_found && stat.overload) begin
                    cmd.qscan_init_free = 1'b1;
                    state_next          = S_QSCAN_BAL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_QSCAN_DISP: begin
                if (!stat.qscan_done) begin
                    cmd.qscan_run = 1'b1;
                end else begin
                    state_next = S_TAKE_PICK;
                end
            end
            S_QSCAN_BAL: begin
                if (!stat.qscan_done) begin
                    cmd.qscan_run = 1'b1;
                end else begin
                    state_next = S_BAL_FOUND;
                end
            end
            S_BAL_FOUND: begin
                if (!stat.qscan_found) begin
                    state_next = S_FINISH;
                end else if (stat.pc_full) begin
                    cmd.set_result    = 1'b1;
                    cmd.result_status = ST_FULL;
                    state_next        = S_FINISH;
                end else begin
                    state_next = S_TAKE_PICK;
                end
            end
            S_TAKE_PICK: begin
                cmd.take_read_pick = 1'b1;
                state_next         = S_TAKE_LAST;
            end
            S_TAKE_LAST: begin
                cmd.take_read_last = 1'b1;
                state_next         = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                cmd.take_write = 1'b1;
                state_next     = stat.is_dispatch ? S_FINISH : S_MOVE;
            end
            S_MOVE: begin
                cmd.move_commit = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/pcrqb_dpath.sv
module pcrqb_dpath #(
    parameter int NUM_CORE_MAX = pcrqb_pkg::NUM_CORE_MAX_DEF,
    parameter int NUM_TASKS    = pcrqb_pkg::NUM_TASKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pcrqb_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pcrqb_pkg::out_item_t                m_item,
    input  logic                                cfg_we,
    input  logic [pcrqb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcrqb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  pcrqb_pkg::cmd_t                     cmd,
    output pcrqb_pkg::stat_t                    stat
);
    import pcrqb_pkg::*;

    localparam int CW   = $clog2(NUM_CORE_MAX);
    localparam int NW   = $clog2(NUM_CORE_MAX + 1);
    localparam int JW   = $clog2(NUM_CORE_MAX + 2);
    localparam int TW   = $clog2(NUM_TASKS);
    localparam int KW   = $clog2(NUM_TASKS + 1);
    localparam int BW   = ((KW > MARGIN_W) ? KW : MARGIN_W) + 1;
    localparam int SAW  = CW + TW;
    localparam int SDEP = NUM_CORE_MAX * (1 << TW);

    // Configuration registers.
    logic [NCORES_W-1:0] num_cores_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // Latched request.
    logic [REQ_W-1:0]  req_reg;
    logic [CORE_W-1:0] core_reg;
    logic [TASK_W-1:0] task_reg;
    logic [TIME_W-1:0] ctime_reg;
    logic              pin_reg;

    // Per-core state.
    logic [KW-1:0]       count_reg [NUM_CORE_MAX];
    logic [PERIOD_W-1:0] bal_reg   [NUM_CORE_MAX];

    // Memories.
    logic [TW-1:0]     slot_mem    [SDEP];
    logic [CW-1:0]     home_mem    [NUM_TASKS];
    logic [TIME_W-1:0] created_mem [NUM_TASKS];
    logic              pinned_mem  [NUM_TASKS];
    logic [TW-1:0]     slot_rd_reg;
    logic [CW-1:0]     home_rd_reg;
    logic [TIME_W-1:0] created_rd_reg;
    logic              pinned_rd_reg;

    // Core load scan.
    logic [JW-1:0] lj_reg;
    logic          lvalid_reg;
    logic [CW-1:0] lbest_reg;
    logic [KW-1:0] lcnt_reg;

    // Queue scan pipeline.
    logic [KW-1:0]     qi_reg;
    logic              qv1_reg;
    logic [TW-1:0]     qi1_reg;
    logic              qv2_reg;
    logic [TW-1:0]     qi2_reg;
    logic              qmin_reg;
    logic              have_reg;
    logic [TW-1:0]     pick_reg;
    logic [TIME_W-1:0] best_time_reg;

    logic [CW-1:0] home_reg;
    logic [TW-1:0] take_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [TASK_W-1:0]   res_chosen_reg;
    logic [CORE_W-1:0]   res_target_reg;
    logic                res_moved_reg;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic [NW-1:0]     n_use;
    logic [CW-1:0]     core_idx;
    logic [TW-1:0]     tidx;
    logic [KW-1:0]     count_core;
    logic [KW-1:0]     count_home;
    logic [KW-1:0]     count_pc;
    logic [KW-1:0]     count_j;
    logic [PERIOD_W:0] bal_next;
    logic              balance_due;
    logic              qs_issue;
    logic [SAW-1:0]    slot_raddr;
    logic              slot_we;
    logic [SAW-1:0]    slot_waddr;
    logic [TW-1:0]     slot_wdata;
    logic              home_we;
    logic [TW-1:0]     home_waddr;
    logic [CW-1:0]     home_wdata;

    always_comb begin
        if (num_cores_reg == '0) begin
            n_use = NW'(1);
        end else if (32'(num_cores_reg) > NUM_CORE_MAX) begin
            n_use = NW'(NUM_CORE_MAX);
        end else begin
            n_use = NW'(num_cores_reg);
        end
    end

    assign core_idx    = CW'(core_reg);
    assign tidx        = TW'(task_reg);
    assign count_core  = count_reg[core_idx];
    assign count_home  = count_reg[home_reg];
    assign count_pc    = count_reg[lbest_reg];
    assign count_j     = count_reg[lj_reg[CW-1:0]];
    assign bal_next    = {1'b0, bal_reg[core_idx]} + (PERIOD_W + 1)'(1);
    assign balance_due = (bal_next >= {1'b0, period_reg});
    assign qs_issue    = cmd.qscan_run && (qi_reg < count_core);

    assign stat.is_admit    = (req_reg == REQ_ADMIT);
    assign stat.is_ready    = (req_reg == REQ_READY);
    assign stat.is_dispatch = (req_reg == REQ_DISPATCH);
    assign stat.task_ok     = (32'(task_reg) < NUM_TASKS);
    assign stat.core_ok     = (32'(core_reg) < 32'(n_use));
    assign stat.core_odd    = core_reg[0];
    assign stat.core_empty  = (count_core == '0);
    assign stat.balance_due = balance_due;
    assign stat.load_done   = (32'(lj_reg) >= 32'(n_use));
    assign stat.load_found  = lvalid_reg;
    assign stat.overload    = (BW'(count_core) >= (BW'(lcnt_reg) + BW'(margin_reg)));
    assign stat.qscan_done  = (qi_reg >= count_core) && !qv1_reg && !qv2_reg;
    assign stat.qscan_found = have_reg;
    assign stat.pc_full     = (count_pc == KW'(NUM_TASKS));
    assign stat.out_free    = !m_valid_reg || m_ready;

    // Queue slot port selection.
    always_comb begin
        if (cmd.take_read_last) begin
            slot_raddr = {core_idx, TW'(count_core - KW'(1))};
        end else if (cmd.take_read_pick) begin
            slot_raddr = {core_idx, pick_reg};
        end else begin
            slot_raddr = {core_idx, qi_reg[TW-1:0]};
        end
        slot_we    = 1'b0;
        slot_waddr = {core_idx, pick_reg};
        slot_wdata = slot_rd_reg;
        if (cmd.enqueue && (count_home != KW'(NUM_TASKS))) begin
            slot_we    = 1'b1;
            slot_waddr = {home_reg, count_home[TW-1:0]};
            slot_wdata = tidx;
        end else if (cmd.take_write) begin
            slot_we = 1'b1;
        end else if (cmd.move_commit) begin
            slot_we    = 1'b1;
            slot_waddr = {lbest_reg, count_pc[TW-1:0]};
            slot_wdata = take_reg;
        end
        home_we    = cmd.admit_write || cmd.move_commit;
        home_waddr = cmd.move_commit ? take_reg : tidx;
        home_wdata = cmd.move_commit ? lbest_reg : lbest_reg;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (home_we) begin
            home_mem[home_waddr] <= home_wdata;
        end
        home_rd_reg <= home_mem[tidx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.admit_write) begin
            created_mem[tidx] <= ctime_reg;
            pinned_mem[tidx]  <= pin_reg;
        end
        created_rd_reg <= created_mem[slot_rd_reg];
        pinned_rd_reg  <= pinned_mem[slot_rd_reg];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cores_reg <= NUM_CORES_RST;
            period_reg    <= PERIOD_RST;
            margin_reg    <= MARGIN_RST;
            for (int c = 0; c < NUM_CORE_MAX; c++) begin
                count_reg[c] <= '0;
                bal_reg[c]   <= '0;
            end
            lj_reg      <= '0;
            lvalid_reg  <= 1'b0;
            qi_reg      <= '0;
            qv1_reg     <= 1'b0;
            qv2_reg     <= 1'b0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_NUM_CORES:       num_cores_reg <= cfg_wdata[NCORES_W-1:0];
                    CFG_BALANCE_PERIOD:  period_reg    <= cfg_wdata[PERIOD_W-1:0];
                    CFG_OVERLOAD_MARGIN: margin_reg    <= cfg_wdata[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.tick_count) begin
                bal_reg[core_idx] <= balance_due ? '0 : bal_next[PERIOD_W-1:0];
            end
            if (cmd.enqueue && (count_home != KW'(NUM_TASKS))) begin
                count_reg[home_reg] <= count_home + KW'(1);
            end
            if (cmd.take_write) begin
                count_reg[core_idx] <= count_core - KW'(1);
            end
            if (cmd.move_commit) begin
                count_reg[lbest_reg] <= count_pc + KW'(1);
            end
            if (cmd.load_init_even || cmd.load_init_odd) begin
                lj_reg     <= cmd.load_init_odd ? JW'(1) : '0;
                lvalid_reg <= 1'b0;
            end else if (cmd.load_step) begin
                lj_reg <= lj_reg + JW'(2);
                if (!lvalid_reg || (count_j < lcnt_reg)) begin
                    lvalid_reg <= 1'b1;
                end
            end
            if (cmd.qscan_init_min || cmd.qscan_init_free) begin
                qi_reg   <= '0;
                qv1_reg  <= 1'b0;
                qv2_reg  <= 1'b0;
                have_reg <= 1'b0;
            end else if (cmd.qscan_run) begin
                if (qs_issue) begin
                    qi_reg <= qi_reg + KW'(1);
                end
                qv1_reg <= qs_issue;
                qv2_reg <= qv1_reg;
                if (qv2_reg) begin
                    if (qmin_reg) begin
                        if (!have_reg || (created_rd_reg < best_time_reg)) begin
                            have_reg <= 1'b1;
                        end
                    end else if (!have_reg && !pinned_rd_reg) begin
                        have_reg <= 1'b1;
                    end
                end
            end
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg        <= s_item.req_type;
            core_reg       <= s_item.core;
            task_reg       <= s_item.task_id;
            ctime_reg      <= s_item.create_time;
            pin_reg        <= s_item.pinned;
            res_status_reg <= ST_IGNORED;
            res_chosen_reg <= '0;
            res_target_reg <= '0;
            res_moved_reg  <= 1'b0;
        end
        if (cmd.set_result) begin
            res_status_reg <= cmd.result_status;
        end
        if (cmd.load_step && (!lvalid_reg || (count_j < lcnt_reg))) begin
            lbest_reg <= lj_reg[CW-1:0];
            lcnt_reg  <= count_j;
        end
        if (cmd.admit_write) begin
            home_reg <= lbest_reg;
        end
        if (cmd.home_from_mem) begin
            home_reg <= home_rd_reg;
        end
        if (cmd.enqueue) begin
            res_target_reg <= CORE_W'(home_reg);
            res_status_reg <= (count_home == KW'(NUM_TASKS)) ? ST_FULL : ST_DONE;
        end
        if (cmd.qscan_init_min || cmd.qscan_init_free) begin
            qmin_reg <= cmd.qscan_init_min;
        end
        if (cmd.qscan_run) begin
            qi1_reg <= qi_reg[TW-1:0];
            qi2_reg <= qi1_reg;
            if (qv2_reg) begin
                if (qmin_reg) begin
                    if (!have_reg || (created_rd_reg < best_time_reg)) begin
                        pick_reg      <= qi2_reg;
                        best_time_reg <= created_rd_reg;
                    end
                end else if (!have_reg && !pinned_rd_reg) begin
                    pick_reg <= qi2_reg;
                end
            end
        end
        if (cmd.pick_zero) begin
            pick_reg <= '0;
        end
        if (cmd.take_read_last) begin
            take_reg <= slot_rd_reg;
        end
        if (cmd.take_write) begin
            res_chosen_reg <= TASK_W'(take_reg);
            res_status_reg <= ST_DONE;
        end
        if (cmd.move_commit) begin
            res_target_reg <= CORE_W'(lbest_reg);
            res_moved_reg  <= 1'b1;
        end
        if (cmd.publish) begin
            m_item_reg.status      <= res_status_reg;
            m_item_reg.chosen_task <= res_chosen_reg;
            m_item_reg.target_core <= res_target_reg;
            m_item_reg.moved       <= res_moved_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: sv/per_core_ready_queue_balancer.sv
// The time from the accepting edge to a valid result grows with num_cores for an admit,
// with the queue length for a performance-core dispatch, with both for a balancing tick
// that moves a task, and with every stalled cycle of the output.
// Throughput: one transaction is processed at a time; the next is taken once the result
// has been written into the output register. The queue memory's single read port sets the
// scan pace.
// Reset (aresetn, synchronous, active low) clears queue counts and tick counters and
// returns the configuration to its defaults.
module per_core_ready_queue_balancer #(
    parameter int NUM_CORE_MAX = pcrqb_pkg::NUM_CORE_MAX_DEF,
    parameter int NUM_TASKS    = pcrqb_pkg::NUM_TASKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pcrqb_pkg::in_item_t              s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pcrqb_pkg::out_item_t             m_item,
    input  logic                             cfg_we,
    input  logic [pcrqb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcrqb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pcrqb_pkg::*;

    // The controller sequences each request through load scans, queue scans and the
    // remove-by-last-entry step; the datapath holds queues, task attributes and loads.
    cmd_t  cmd;
    stat_t stat;

    pcrqb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // A finished result waits in the output register while a new transaction may start.
    pcrqb_dpath #(
        .NUM_CORE_MAX (NUM_CORE_MAX),
        .NUM_TASKS    (NUM_TASKS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: bench/per_core_ready_queue_balancer_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the per-core ready queue balancer.
// A driver feeds scheduling requests from a queue of pending transactions, and a
// predictor in this file works out the reply for every accepted transaction. A monitor
// compares each reply with the oldest prediction, field by field. The run is split into
// phases; between phases the sender waits until every reply has arrived, and then the
// configuration registers are rewritten while the block is idle.
module per_core_ready_queue_balancer_tb;
    import pcrqb_pkg::*;

    localparam int NCORE      = NUM_CORE_MAX_DEF;
    localparam int NTASK      = NUM_TASKS_DEF;
    localparam int CYCLE_STOP = 2000000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    per_core_ready_queue_balancer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the scheduler: queues, loads, tick counters and task attributes.
    logic [TASK_W-1:0]   rq_slot [NCORE][NTASK];
    int unsigned         rq_load [NCORE];
    int unsigned         tick_count [NCORE];
    logic [CORE_W-1:0]   task_home [NTASK];
    logic [TIME_W-1:0]   task_born [NTASK];
    logic                task_pin [NTASK];
    logic [NCORES_W-1:0] sh_cores;
    logic [PERIOD_W-1:0] sh_period;
    logic [MARGIN_W-1:0] sh_margin;

    in_item_t  pending_reqs[$];
    out_item_t awaited_replies[$];
    int        admitted_ids[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    bit        no_idle = 1'b0;

    function automatic int active_cores();
        if (sh_cores == 0) return 1;
        if (sh_cores > NCORE) return NCORE;
        return int'(sh_cores);
    endfunction

    // Removes entry idx of a core's queue, back-filling the hole with the last entry.
    function automatic logic [TASK_W-1:0] pull_entry(int c, int idx);
        logic [TASK_W-1:0] t;
        t = rq_slot[c][idx];
        rq_slot[c][idx] = rq_slot[c][rq_load[c]-1];
        rq_load[c]--;
        return t;
    endfunction

    function automatic bit push_entry(int c, logic [TASK_W-1:0] t);
        if (rq_load[c] >= NTASK) return 1'b0;
        rq_slot[c][rq_load[c]] = t;
        rq_load[c]++;
        return 1'b1;
    endfunction

    // Works out the reply to one request and updates the shadow state.
    function automatic out_item_t schedule_reply(in_item_t rq);
        out_item_t r;
        int n, c, best, pick, pc, found;
        logic [TASK_W-1:0] t;
        n = active_cores();
        c = int'(rq.core);
        r = '0;
        r.status = ST_IGNORED;
        if (rq.req_type == REQ_ADMIT || rq.req_type == REQ_READY) begin
            t = rq.task_id;
            if (rq.req_type == REQ_ADMIT) begin
                best = 0;
                for (int i = 2; i < n; i += 2)
                    if (rq_load[i] < rq_load[best]) best = i;
                task_born[t] = rq.create_time;
                task_pin[t]  = rq.pinned;
                task_home[t] = CORE_W'(best);
            end
            r.target_core = task_home[t];
            r.status = push_entry(int'(task_home[t]), t) ? ST_DONE : ST_FULL;
        end else if (c < n) begin
            if (rq.req_type == REQ_DISPATCH) begin
                if (rq_load[c] == 0) begin
                    r.status = ST_NONE;
                end else begin
                    pick = 0;
                    if (c % 2 == 1)
                        for (int i = 1; i < rq_load[c]; i++)
                            if (task_born[rq_slot[c][i]] < task_born[rq_slot[c][pick]])
                                pick = i;
                    r.chosen_task = pull_entry(c, pick);
                    r.status = ST_DONE;
                end
            end else begin
                r.status = ST_NONE;
                if (c % 2 == 0) begin
                    if (tick_count[c] + 1 < sh_period) begin
                        tick_count[c]++;
                    end else begin
                        tick_count[c] = 0;
                        pc = -1;
                        for (int i = 1; i < n; i += 2)
                            if (pc < 0 || rq_load[i] < rq_load[pc]) pc = i;
                        if (pc >= 0 && rq_load[c] >= rq_load[pc] + sh_margin) begin
                            found = -1;
                            for (int i = 0; i < rq_load[c]; i++)
                                if (found < 0 && !task_pin[rq_slot[c][i]]) found = i;
                            if (found >= 0) begin
                                if (rq_load[pc] >= NTASK) begin
                                    r.status = ST_FULL;
                                end else begin
                                    t = pull_entry(c, found);
                                    task_home[t] = CORE_W'(pc);
                                    void'(push_entry(pc, t));
                                    r.chosen_task = t;
                                    r.target_core = CORE_W'(pc);
                                    r.moved = 1'b1;
                                    r.status = ST_DONE;
                                end
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, none at all in a burst phase.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: a transaction is predicted at the edge at which it is accepted.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready)
                awaited_replies.push_back(schedule_reply(s_item));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_item   <= pending_reqs.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: replies are checked against the oldest prediction, and the result side
    // stalls at random in the same fashion as the sender.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply %p", m_item);
                end else begin
                    out_item_t e;
                    e = awaited_replies.pop_front();
                    if (m_item.status !== e.status || m_item.chosen_task !== e.chosen_task ||
                        m_item.target_core !== e.target_core || m_item.moved !== e.moved) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reply differs: expected %p, got %p", e, m_item);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                recv_gap <= m_valid ? pick_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_STOP) begin
            $display("per_core_ready_queue_balancer: mismatch");
            $finish;
        end
    end

    // Register writes are only issued while nothing is in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_NUM_CORES) sh_cores = val[NCORES_W-1:0];
        else if (idx == CFG_BALANCE_PERIOD) sh_period = val;
        else sh_margin = val[MARGIN_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Polled at every edge, as a queue's size gives no event to wait on.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic queue_req(logic [REQ_W-1:0] kind, int c, int t, logic [TIME_W-1:0] tm,
                             bit pin);
        in_item_t it;
        it.req_type    = kind;
        it.core        = CORE_W'(c);
        it.task_id     = TASK_W'(t);
        it.create_time = tm;
        it.pinned      = pin;
        if (kind == REQ_ADMIT) admitted_ids.push_back(t);
        pending_reqs.push_back(it);
    endtask

    // A ready request is only made for a task that has been admitted, since a never
    // admitted task has no home. Without one yet, the request becomes an admit.
    task automatic queue_random(int p_admit, int p_ready, int p_disp);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_admit || (admitted_ids.size() == 0 && r < p_admit + p_ready))
            queue_req(REQ_ADMIT, $urandom_range(0, 3), $urandom_range(0, NTASK - 1),
                      $urandom(), $urandom_range(0, 3) == 0);
        else if (r < p_admit + p_ready)
            queue_req(REQ_READY, $urandom_range(0, 3),
                      admitted_ids[$urandom_range(0, admitted_ids.size() - 1)],
                      $urandom(), $urandom_range(0, 1));
        else if (r < p_admit + p_ready + p_disp)
            queue_req(REQ_DISPATCH, $urandom_range(0, 3), $urandom_range(0, NTASK - 1),
                      $urandom(), $urandom_range(0, 1));
        else
            queue_req(REQ_TICK, $urandom_range(0, 3), $urandom_range(0, NTASK - 1),
                      $urandom(), $urandom_range(0, 1));
    endtask

    initial begin
        for (int c = 0; c < NCORE; c++) begin
            rq_load[c] = 0;
            tick_count[c] = 0;
        end
        sh_cores  = NUM_CORES_RST;
        sh_period = PERIOD_RST;
        sh_margin = MARGIN_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening under the reset configuration: empty dispatch, extreme ids,
        // times and flags, odd-core ticks and a full balance period on core 0.
        queue_req(REQ_DISPATCH, 1, 0, 0, 0);
        queue_req(REQ_DISPATCH, 0, 0, 0, 0);
        queue_req(REQ_ADMIT, 0, 0, 32'hFFFF_FFFF, 1);
        queue_req(REQ_ADMIT, 3, 63, 32'h0000_0000, 0);
        queue_req(REQ_ADMIT, 1, 21, 32'h5555_5555, 0);
        queue_req(REQ_ADMIT, 2, 42, 32'hAAAA_AAAA, 1);
        queue_req(REQ_READY, 0, 0, 0, 0);
        queue_req(REQ_READY, 0, 63, 32'hFFFF_FFFF, 1);
        queue_req(REQ_READY, 0, 21, 0, 0);
        queue_req(REQ_READY, 0, 21, 0, 0);
        queue_req(REQ_TICK, 1, 0, 0, 0);
        queue_req(REQ_TICK, 3, 0, 0, 0);
        for (int i = 0; i < 5; i++) queue_req(REQ_TICK, 0, 0, 0, 0);
        queue_req(REQ_DISPATCH, 1, 0, 0, 0);
        queue_req(REQ_DISPATCH, 3, 0, 0, 0);
        queue_req(REQ_DISPATCH, 0, 0, 0, 0);
        queue_req(REQ_DISPATCH, 2, 0, 0, 0);
        drain();

        // Each phase sets the registers, then sends a random mix. The single-core phase
        // leans on ready requests so that queues fill up; the multi-core zero-margin phases give
        // frequent migrations. The core counts of zero, five and seven are out of range.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_NUM_CORES, 1);
                    write_reg(CFG_BALANCE_PERIOD, 1);
                    write_reg(CFG_OVERLOAD_MARGIN, 0);
                end
                1: begin
                    write_reg(CFG_NUM_CORES, 4);
                    write_reg(CFG_BALANCE_PERIOD, 1);
                    write_reg(CFG_OVERLOAD_MARGIN, 0);
                end
                2: begin
                    write_reg(CFG_NUM_CORES, 2);
                    write_reg(CFG_BALANCE_PERIOD, 255);
                    write_reg(CFG_OVERLOAD_MARGIN, 64);
                end
                3: begin
                    write_reg(CFG_NUM_CORES, 3);
                    write_reg(CFG_BALANCE_PERIOD, 2);
                    write_reg(CFG_OVERLOAD_MARGIN, 1);
                end
                4: begin
                    write_reg(CFG_NUM_CORES, 0);
                    write_reg(CFG_BALANCE_PERIOD, 3);
                end
                5: begin
                    write_reg(CFG_NUM_CORES, 7);
                    write_reg(CFG_BALANCE_PERIOD, 1);
                    write_reg(CFG_OVERLOAD_MARGIN, 2);
                end
                6: begin
                    write_reg(CFG_NUM_CORES, 5);
                    write_reg(CFG_OVERLOAD_MARGIN, 0);
                end
                default: begin
                    write_reg(CFG_NUM_CORES, 4);
                    write_reg(CFG_BALANCE_PERIOD, 5);
                    write_reg(CFG_OVERLOAD_MARGIN, 3);
                end
            endcase
            no_idle = (ph % 3 == 2);
            for (int i = 0; i < 250; i++) begin
                case (ph)
                    0: queue_random(10, 75, 5);
                    1, 5: queue_random(25, 35, 15);
                    2: queue_random(30, 30, 20);
                    default: queue_random(20, 35, 25);
                endcase
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("per_core_ready_queue_balancer: match");
        else
            $display("per_core_ready_queue_balancer: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/pcrqb_pkg.sv
sv/pcrqb_ctrl.sv
sv/pcrqb_dpath.sv
sv/per_core_ready_queue_balancer.sv
bench/per_core_ready_queue_balancer_tb.sv
